FILE: hw/rtl/clt_pkg.sv
// Shared types and constants for the command line tokenizer.
package clt_pkg;

   localparam int DEF_MAX_ARGS      = 8;
   localparam int DEF_MAX_TOKEN_LEN = 32;
   localparam int DEF_LINE_MAX      = 255;

   localparam int CHAR_W  = 8;
   localparam int INDEX_W = 4;
   localparam int POS_W   = 5;
   localparam int LINE_W  = 8;

   localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [CHAR_W-1:0] CH_NL     = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
   localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
   localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;

   typedef enum logic [4:0] {
      PH_LEAD = 5'b00001,
      PH_CMD  = 5'b00010,
      PH_GAP  = 5'b00100,
      PH_ARG  = 5'b01000,
      PH_DROP = 5'b10000
   } phase_type;

   typedef struct packed {
      phase_type          phase;
      logic               esc;
      logic               quote;
      logic [INDEX_W-1:0] tok;
      logic [POS_W-1:0]   pos;
      logic               started;
      logic [LINE_W-1:0]  line_cnt;
   } parse_state_type;

   localparam parse_state_type PARSE_START = '{
      phase:    PH_LEAD,
      esc:      1'b0,
      quote:    1'b0,
      tok:      '0,
      pos:      '0,
      started:  1'b0,
      line_cnt: '0
   };

   typedef struct packed {
      logic [INDEX_W-1:0] idx;
      logic [POS_W-1:0]   pos;
      logic [CHAR_W-1:0]  chr;
      logic               valid;
      logic               tok_end;
      logic               done;
      logic               trunc;
   } tok_result_type;

endpackage

FILE: hw/rtl/clt_parse.sv
// Next-state and result logic for one byte of the command line.
module clt_parse #(
   parameter int MAX_ARGS      = clt_pkg::DEF_MAX_ARGS,
   parameter int MAX_TOKEN_LEN = clt_pkg::DEF_MAX_TOKEN_LEN,
   parameter int LINE_MAX      = clt_pkg::DEF_LINE_MAX
) (
   input  clt_pkg::parse_state_type     cur,
   input  logic [clt_pkg::CHAR_W-1:0]   in_char,
   input  logic                         in_last,
   output clt_pkg::parse_state_type     nxt,
   output clt_pkg::tok_result_type      res,
   output logic                         emit
);

   localparam logic [clt_pkg::POS_W-1:0]   POS_LIMIT  = clt_pkg::POS_W'(MAX_TOKEN_LEN - 1);
   localparam logic [clt_pkg::INDEX_W-1:0] ARG_LIMIT  = clt_pkg::INDEX_W'(MAX_ARGS);
   localparam logic [clt_pkg::LINE_W-1:0]  LINE_LIMIT = clt_pkg::LINE_W'(LINE_MAX);

   logic is_quote;
   logic is_lit;
   logic is_nl;

   assign is_quote = (in_char == clt_pkg::CH_DQUOTE) || (in_char == clt_pkg::CH_SQUOTE);
   assign is_lit   = is_quote || (in_char == clt_pkg::CH_BSLASH);
   assign is_nl    = (in_char == clt_pkg::CH_NL);

   always_comb begin
      logic keep;
      logic do_arg;
      logic start;
      keep   = 1'b0;
      do_arg = 1'b0;
      start  = 1'b0;
      nxt    = cur;
      res    = '0;

      if (!is_nl) begin
         if (cur.line_cnt >= LINE_LIMIT) begin
            res.trunc = 1'b1;
         end else begin
            nxt.line_cnt = cur.line_cnt + 8'd1;
            unique case (cur.phase)
               clt_pkg::PH_LEAD: begin
                  if (in_char != clt_pkg::CH_SPACE) begin
                     nxt.phase   = clt_pkg::PH_CMD;
                     nxt.tok     = '0;
                     nxt.started = 1'b1;
                     nxt.pos     = '0;
                     keep        = 1'b1;
                  end
               end
               clt_pkg::PH_CMD: begin
                  if (in_char == clt_pkg::CH_SPACE) begin
                     res.pos     = cur.pos;
                     res.tok_end = 1'b1;
                     nxt.phase   = clt_pkg::PH_GAP;
                     nxt.pos     = '0;
                     nxt.started = 1'b0;
                  end else begin
                     keep = 1'b1;
                  end
               end
               clt_pkg::PH_GAP: begin
                  nxt.esc = 1'b0;
                  if (cur.esc && is_lit) begin
                     start = 1'b1;
                  end else if (in_char == clt_pkg::CH_BSLASH) begin
                     nxt.esc = 1'b1;
                  end else if (in_char != clt_pkg::CH_SPACE) begin
                     start = 1'b1;
                  end
                  if (start) begin
                     if (cur.tok >= ARG_LIMIT) begin
                        nxt.phase = clt_pkg::PH_DROP;
                        res.trunc = 1'b1;
                     end else begin
                        nxt.tok     = cur.tok + 4'd1;
                        nxt.phase   = clt_pkg::PH_ARG;
                        nxt.started = 1'b1;
                        nxt.pos     = '0;
                        nxt.quote   = 1'b0;
                        if (cur.esc && is_lit) begin
                           keep = 1'b1;
                        end else begin
                           do_arg = 1'b1;
                        end
                     end
                  end
               end
               clt_pkg::PH_ARG: begin
                  do_arg = 1'b1;
               end
               clt_pkg::PH_DROP: begin
                  res.trunc = 1'b1;
               end
               default: begin
                  res.trunc = 1'b1;
               end
            endcase

            if (do_arg) begin
               if (nxt.esc && is_lit) begin
                  nxt.esc = 1'b0;
                  keep    = 1'b1;
               end else begin
                  nxt.esc = 1'b0;
                  if (in_char == clt_pkg::CH_BSLASH) begin
                     nxt.esc = 1'b1;
                  end else if (is_quote) begin
                     nxt.quote = ~nxt.quote;
                  end else if ((in_char == clt_pkg::CH_SPACE) && !nxt.quote) begin
                     res.pos     = nxt.pos;
                     res.tok_end = 1'b1;
                     nxt.phase   = clt_pkg::PH_GAP;
                     nxt.pos     = '0;
                     nxt.started = 1'b0;
                  end else begin
                     keep = 1'b1;
                  end
               end
            end

            if (keep) begin
               res.pos = nxt.pos;
               if (nxt.pos < POS_LIMIT) begin
                  res.chr   = in_char;
                  res.valid = 1'b1;
                  nxt.pos   = nxt.pos + 5'd1;
               end else begin
                  res.trunc = 1'b1;
               end
            end
         end
      end

      res.idx = nxt.tok;
      if (is_nl || in_last) begin
         if (nxt.started) begin
            res.tok_end = 1'b1;
            if (!res.valid) begin
               res.pos = nxt.pos;
            end
         end
         res.done = 1'b1;
         nxt      = clt_pkg::PARSE_START;
      end

      emit = res.valid | res.tok_end | res.done | res.trunc;
   end

endmodule

FILE: hw/rtl/command_line_tokenizer.sv
// Top level of the command line tokenizer: input stage, parse state and result register.
//
// Usage: bytes of a console line enter on the req_ channel, one item per byte,
// with req_in_line_end marking a last byte when no newline follows. Each item
// that keeps a character, ends a token, ends the line or drops a byte gives one
// result item on the rsp_ channel; skipped spaces, quotes and escapes give none.
// An item is taken when valid is high and stall is low on its channel.
// Each accepted byte is held in the input register, then parsed into the result
// register. Throughput: one byte per cycle while the receiver does not stall; the
// parse state is updated by a single pass of logic from the input register to the
// result register. When the receiver stalls, the pending result holds; the input
// register takes one more byte only if it was empty; req_stall is high while it is full.
// Reset (synchronous, active high) empties both registers and returns the
// parser to the start of a line.
module command_line_tokenizer #(
   parameter int MAX_ARGS      = clt_pkg::DEF_MAX_ARGS,
   parameter int MAX_TOKEN_LEN = clt_pkg::DEF_MAX_TOKEN_LEN,
   parameter int LINE_MAX      = clt_pkg::DEF_LINE_MAX
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [clt_pkg::CHAR_W-1:0]    req_in_char,
   input  logic                          req_in_line_end,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [clt_pkg::INDEX_W-1:0]   rsp_tok_index,
   output logic [clt_pkg::POS_W-1:0]     rsp_tok_char_pos,
   output logic [clt_pkg::CHAR_W-1:0]    rsp_tok_char,
   output logic                          rsp_char_valid,
   output logic                          rsp_tok_end,
   output logic                          rsp_line_done,
   output logic                          rsp_truncated
);

   logic                        in_vld_ff, in_vld_in;
   logic [clt_pkg::CHAR_W-1:0]  in_char_ff;
   logic                        in_last_ff;
   clt_pkg::parse_state_type    state_ff, state_in;
   logic                        out_vld_ff, out_vld_in;
   clt_pkg::tok_result_type     out_ff;
   clt_pkg::tok_result_type     step_res;
   logic                        step_emit;
   logic                        advance;
   logic                        req_take;

   assign advance   = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign in_vld_in = req_take || (in_vld_ff && !advance);

   clt_parse #(
      .MAX_ARGS      (MAX_ARGS),
      .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
      .LINE_MAX      (LINE_MAX)
   ) u_parse (
      .cur     (state_ff),
      .in_char (in_char_ff),
      .in_last (in_last_ff),
      .nxt     (state_in),
      .res     (step_res),
      .emit    (step_emit)
   );

   always_comb begin
      if (advance) begin
         out_vld_in = step_emit;
      end else if (out_vld_ff && rsp_stall) begin
         out_vld_in = 1'b1;
      end else begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         state_ff   <= clt_pkg::PARSE_START;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff <= req_in_char;
         in_last_ff <= req_in_line_end;
      end
      if (advance && step_emit) begin
         out_ff <= step_res;
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_tok_index    = out_ff.idx;
   assign rsp_tok_char_pos = out_ff.pos;
   assign rsp_tok_char     = out_ff.chr;
   assign rsp_char_valid   = out_ff.valid;
   assign rsp_tok_end      = out_ff.tok_end;
   assign rsp_line_done    = out_ff.done;
   assign rsp_truncated    = out_ff.trunc;

`ifndef NO_ASSERTIONS
   a_line_done_restarts: assert property (@(posedge clock) disable iff (reset)
      (advance && step_res.done) |=>
         (state_ff.phase == clt_pkg::PH_LEAD) && (state_ff.line_cnt == '0) &&
         !state_ff.started)
      else $error("Parse state did not return to start after a line end.");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_tok_index <= clt_pkg::INDEX_W'(MAX_ARGS)))
      else $error("Token index beyond the argument limit.");

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_char_valid) |->
         (rsp_tok_char_pos < clt_pkg::POS_W'(MAX_TOKEN_LEN - 1)))
      else $error("Kept character beyond the token length limit.");

   a_result_from_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(advance))
      else $error("Result appeared without a byte being processed.");
`endif

endmodule

FILE: tb/command_line_tokenizer_tb.sv
// Self-checking testbench for the command line tokenizer with random line traffic.
`timescale 1ns / 100ps

module command_line_tokenizer_tb;

   localparam int MAX_ARGS      = clt_pkg::DEF_MAX_ARGS;
   localparam int MAX_TOKEN_LEN = clt_pkg::DEF_MAX_TOKEN_LEN;
   localparam int LINE_MAX      = clt_pkg::DEF_LINE_MAX;

   typedef struct {
      logic [clt_pkg::CHAR_W-1:0] chr;
      logic                       line_end;
      bit                         drain;
   } line_byte_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [clt_pkg::CHAR_W-1:0]   req_in_char = '0;
   logic                         req_in_line_end = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [clt_pkg::INDEX_W-1:0]  rsp_tok_index;
   logic [clt_pkg::POS_W-1:0]    rsp_tok_char_pos;
   logic [clt_pkg::CHAR_W-1:0]   rsp_tok_char;
   logic                         rsp_char_valid;
   logic                         rsp_tok_end;
   logic                         rsp_line_done;
   logic                         rsp_truncated;

   line_byte_type                pending_bytes[$];
   line_byte_type                offered;
   bit                           drain_next = 1'b0;
   clt_pkg::tok_result_type      expected_tokens[$];
   clt_pkg::tok_result_type      want_token;
   clt_pkg::tok_result_type      seen_token;
   logic                         req_took = 1'b0;
   int                           mismatch_count = 0;
   int                           results_seen = 0;
   int                           send_gap = 0;
   int                           stall_left = 0;
   int                           hold_left = 0;
   bit                           hold_done = 1'b0;
   int                           send_pct = 0;
   int                           stall_pct = 0;
   int                           idle_cycles = 0;

   // Tokenizer model state.
   clt_pkg::phase_type           tk_phase;
   logic                         tk_esc;
   logic                         tk_quote;
   logic [clt_pkg::INDEX_W-1:0]  tk_num;
   logic [clt_pkg::POS_W-1:0]    tk_pos;
   logic                         tk_started;
   logic [clt_pkg::LINE_W-1:0]   tk_count;
   clt_pkg::tok_result_type      tk_res;

   command_line_tokenizer i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_char      (req_in_char),
      .req_in_line_end  (req_in_line_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_tok_index    (rsp_tok_index),
      .rsp_tok_char_pos (rsp_tok_char_pos),
      .rsp_tok_char     (rsp_tok_char),
      .rsp_char_valid   (rsp_char_valid),
      .rsp_tok_end      (rsp_tok_end),
      .rsp_line_done    (rsp_line_done),
      .rsp_truncated    (rsp_truncated)
   );

   always #4 clock = ~clock;

   function automatic void clear_line_state();
      tk_phase   = clt_pkg::PH_LEAD;
      tk_esc     = 1'b0;
      tk_quote   = 1'b0;
      tk_num     = '0;
      tk_pos     = '0;
      tk_started = 1'b0;
      tk_count   = '0;
   endfunction

   function automatic bit is_quote(input logic [clt_pkg::CHAR_W-1:0] c);
      return c == clt_pkg::CH_DQUOTE || c == clt_pkg::CH_SQUOTE;
   endfunction

   function automatic void store_char(input logic [clt_pkg::CHAR_W-1:0] c);
      tk_res.pos = tk_pos;
      if (tk_pos < MAX_TOKEN_LEN - 1) begin
         tk_res.chr   = c;
         tk_res.valid = 1'b1;
         tk_pos       = tk_pos + 1'b1;
      end else begin
         tk_res.trunc = 1'b1;
      end
   endfunction

   function automatic void close_token();
      tk_res.pos     = tk_pos;
      tk_res.tok_end = 1'b1;
      tk_phase       = clt_pkg::PH_GAP;
      tk_pos         = '0;
      tk_started     = 1'b0;
   endfunction

   function automatic bit open_argument();
      if (tk_num >= MAX_ARGS) begin
         tk_phase     = clt_pkg::PH_DROP;
         tk_res.trunc = 1'b1;
         return 1'b0;
      end
      tk_num     = tk_num + 1'b1;
      tk_phase   = clt_pkg::PH_ARG;
      tk_started = 1'b1;
      tk_pos     = '0;
      tk_quote   = 1'b0;
      return 1'b1;
   endfunction

   function automatic void scan_arg_char(input logic [clt_pkg::CHAR_W-1:0] c);
      if (tk_esc) begin
         tk_esc = 1'b0;
         if (is_quote(c) || c == clt_pkg::CH_BSLASH) begin
            store_char(c);
            return;
         end
      end
      if (c == clt_pkg::CH_BSLASH) begin
         tk_esc = 1'b1;
      end else if (is_quote(c)) begin
         tk_quote = ~tk_quote;
      end else if (c == clt_pkg::CH_SPACE && !tk_quote) begin
         close_token();
      end else begin
         store_char(c);
      end
   endfunction

   // Advances the model by one input byte and queues the result it causes, if any.
   function automatic void tokenize_byte(input logic [clt_pkg::CHAR_W-1:0] c,
                                         input logic last);
      bit gap_done;
      gap_done = 1'b0;
      tk_res = '0;
      if (c != clt_pkg::CH_NL) begin
         if (tk_count >= LINE_MAX) begin
            tk_res.trunc = 1'b1;
         end else begin
            tk_count = tk_count + 1'b1;
            case (tk_phase)
               clt_pkg::PH_LEAD: begin
                  if (c != clt_pkg::CH_SPACE) begin
                     tk_phase   = clt_pkg::PH_CMD;
                     tk_num     = '0;
                     tk_started = 1'b1;
                     tk_pos     = '0;
                     store_char(c);
                  end
               end
               clt_pkg::PH_CMD: begin
                  if (c == clt_pkg::CH_SPACE) close_token();
                  else store_char(c);
               end
               clt_pkg::PH_GAP: begin
                  if (tk_esc) begin
                     tk_esc = 1'b0;
                     if (is_quote(c) || c == clt_pkg::CH_BSLASH) begin
                        if (open_argument()) store_char(c);
                        gap_done = 1'b1;
                     end
                  end
                  if (!gap_done) begin
                     if (c == clt_pkg::CH_BSLASH) begin
                        tk_esc = 1'b1;
                     end else if (c != clt_pkg::CH_SPACE) begin
                        if (open_argument()) scan_arg_char(c);
                     end
                  end
               end
               clt_pkg::PH_ARG: scan_arg_char(c);
               default: tk_res.trunc = 1'b1;
            endcase
         end
      end
      tk_res.idx = tk_num;
      if (c == clt_pkg::CH_NL || last) begin
         if (tk_started) begin
            tk_res.tok_end = 1'b1;
            if (!tk_res.valid) tk_res.pos = tk_pos;
         end
         tk_res.done = 1'b1;
         clear_line_state();
      end
      if (tk_res.valid || tk_res.tok_end || tk_res.done || tk_res.trunc)
         expected_tokens.push_back(tk_res);
   endfunction

   task automatic report_mismatch(input string what, input clt_pkg::tok_result_type want,
                                  input clt_pkg::tok_result_type seen);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display({"%0t %s: expected idx=%0d pos=%0d char=%h valid=%b end=%b done=%b ",
                   "trunc=%b, got idx=%0d pos=%0d char=%h valid=%b end=%b done=%b trunc=%b"},
                  $time, what, want.idx, want.pos, want.chr, want.valid, want.tok_end,
                  want.done, want.trunc, seen.idx, seen.pos, seen.chr, seen.valid,
                  seen.tok_end, seen.done, seen.trunc);
   endtask

   function automatic void add_byte(input logic [clt_pkg::CHAR_W-1:0] c, input logic last);
      pending_bytes.push_back('{chr: c, line_end: last, drain: drain_next});
      drain_next = 1'b0;
   endfunction

   function automatic void add_text(input string s, input logic last);
      for (int i = 0; i < s.len(); i++)
         add_byte(s[i], last && i == s.len() - 1);
   endfunction

   function automatic logic [clt_pkg::CHAR_W-1:0] rand_arg_char();
      case ($urandom_range(0, 11))
         0: return clt_pkg::CH_DQUOTE;
         1: return clt_pkg::CH_SQUOTE;
         2: return clt_pkg::CH_BSLASH;
         3: return clt_pkg::CH_SPACE;
         default: return clt_pkg::CHAR_W'($urandom_range(33, 126));
      endcase
   endfunction

   function automatic void add_word(input int len, input bit is_arg);
      for (int i = 0; i < len; i++) begin
         if (is_arg) add_byte(rand_arg_char(), 1'b0);
         else if ($urandom_range(0, 7) == 0)
            add_byte(clt_pkg::CHAR_W'($urandom_range(128, 255)), 1'b0);
         else add_byte(clt_pkg::CHAR_W'($urandom_range(33, 126)), 1'b0);
      end
   endfunction

   function automatic void finish_line();
      if ($urandom_range(0, 3) == 0) pending_bytes[pending_bytes.size() - 1].line_end = 1'b1;
      else add_byte(clt_pkg::CH_NL, 1'b0);
   endfunction

   function automatic int idle_rate();
      case ($urandom_range(0, 2))
         0: return 0;
         1: return 10;
         default: return 35;
      endcase
   endfunction

   initial begin
      int kind;
      int start;
      bit long_done;
      long_done = 1'b0;
      clear_line_state();

      add_text("\n", 1'b0);
      add_text("c' a\\\" \\ ''\n", 1'b0);
      add_text(" x 'y \\", 1'b1);
      add_byte(8'hFF, 1'b0);
      add_byte(clt_pkg::CH_SPACE, 1'b0);
      add_byte(8'h00, 1'b1);

      drain_next = 1'b1;
      while (pending_bytes.size() < 900) begin
         kind = $urandom_range(0, 19);
         if (pending_bytes.size() > 450 && pending_bytes.size() < 500) drain_next = 1'b1;
         if (!long_done && pending_bytes.size() > 350) begin
            long_done = 1'b1;
            start = pending_bytes.size();
            add_word($urandom_range(1, 6), 1'b0);
            while (pending_bytes.size() - start < 262) begin
               add_byte(clt_pkg::CH_SPACE, 1'b0);
               add_word($urandom_range(26, 34), 1'b1);
            end
            finish_line();
         end else if (kind == 0) begin
            add_word($urandom_range(1, 4), 1'b0);
            repeat ($urandom_range(9, 11)) begin
               add_byte(clt_pkg::CH_SPACE, 1'b0);
               add_word($urandom_range(1, 2), 1'b1);
            end
            finish_line();
         end else if (kind == 1) begin
            if ($urandom_range(0, 1)) begin
               add_word($urandom_range(30, 40), 1'b0);
            end else begin
               add_word($urandom_range(1, 4), 1'b0);
               add_byte(clt_pkg::CH_SPACE, 1'b0);
               add_word($urandom_range(32, 44), 1'b1);
            end
            finish_line();
         end else if (kind < 4) begin
            repeat ($urandom_range(1, 20))
               add_byte(clt_pkg::CHAR_W'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
            add_byte(clt_pkg::CH_NL, 1'b0);
         end else begin
            repeat ($urandom_range(0, 2)) add_byte(clt_pkg::CH_SPACE, 1'b0);
            add_word($urandom_range(1, 6), 1'b0);
            repeat ($urandom_range(0, 5)) begin
               repeat ($urandom_range(1, 2)) add_byte(clt_pkg::CH_SPACE, 1'b0);
               add_word($urandom_range(0, 6), 1'b1);
            end
            if ($urandom_range(0, 3) == 0) add_byte(clt_pkg::CH_SPACE, 1'b0);
            finish_line();
         end
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() != 0 || req_valid) @(posedge clock);
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("command_line_tokenizer_tb: clean");
      else
         $display("command_line_tokenizer_tb: errors");
      $finish;
   end

   initial begin
      #2000000;
      $display("command_line_tokenizer_tb: errors");
      $finish;
   end

   always @(negedge clock) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles % 64 == 0) begin
         send_pct  <= idle_rate();
         stall_pct <= idle_rate();
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else if (!req_valid || req_took) begin
         if (send_gap != 0) begin
            send_gap  <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_bytes.size() == 0
                      || (pending_bytes[0].drain && expected_tokens.size() != 0)) begin
            req_valid <= 1'b0;
         end else if (pending_bytes.size() >= 120 && $urandom_range(0, 99) < send_pct) begin
            send_gap  <= $urandom_range(0, 11);
            req_valid <= 1'b0;
         end else begin
            offered = pending_bytes.pop_front();
            req_valid       <= 1'b1;
            req_in_char     <= offered.chr;
            req_in_line_end <= offered.line_end;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!hold_done && results_seen >= 150) begin
         hold_done <= 1'b1;
         hold_left <= 80;
         rsp_stall <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (pending_bytes.size() >= 120 && $urandom_range(0, 99) < stall_pct) begin
         stall_left <= $urandom_range(0, 11);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_took <= 1'b0;
      end else begin
         req_took <= req_valid && !req_stall;
         if (req_valid && !req_stall) tokenize_byte(req_in_char, req_in_line_end);
         if (rsp_valid && !rsp_stall) begin
            seen_token = {rsp_tok_index, rsp_tok_char_pos, rsp_tok_char, rsp_char_valid,
                          rsp_tok_end, rsp_line_done, rsp_truncated};
            results_seen++;
            if (expected_tokens.size() == 0) begin
               report_mismatch("unexpected result", '0, seen_token);
            end else begin
               want_token = expected_tokens.pop_front();
               if (seen_token !== want_token)
                  report_mismatch("result mismatch", want_token, seen_token);
            end
         end
      end
   end

endmodule

FILE: sim.f
hw/rtl/clt_pkg.sv
hw/rtl/clt_parse.sv
hw/rtl/command_line_tokenizer.sv
tb/command_line_tokenizer_tb.sv
